/* sv/tpss_pkg.sv */
// Package for the timer pair with serial shift block.
// Holds operation and register select codes, config indexes and the counter helper.
// No dependencies.
package tpss_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    localparam logic [2:0] SEL_TL0    = 3'd0;
    localparam logic [2:0] SEL_TH0    = 3'd1;
    localparam logic [2:0] SEL_TL1    = 3'd2;
    localparam logic [2:0] SEL_TH1    = 3'd3;
    localparam logic [2:0] SEL_TCON   = 3'd4;
    localparam logic [2:0] SEL_SBUF   = 3'd5;
    localparam logic [2:0] SEL_STATUS = 3'd6;

    localparam logic [1:0] CFG_TIMER_MODE = 2'd0;
    localparam logic [1:0] CFG_SHIFT_MODE = 2'd1;
    localparam logic [1:0] CFG_IRQ_ENABLE = 2'd2;
    localparam logic [1:0] CFG_BIT_COUNT  = 2'd3;

    localparam logic [1:0] MODE_13BIT  = 2'd0;
    localparam logic [1:0] MODE_16BIT  = 2'd1;
    localparam logic [1:0] MODE_RELOAD = 2'd2;
    localparam logic [1:0] MODE_SPLIT  = 2'd3;

    // TCON bit positions
    localparam int TCON_TR0 = 4;
    localparam int TCON_TF0 = 5;
    localparam int TCON_TR1 = 6;
    localparam int TCON_TF1 = 7;

    localparam logic [3:0] MAX_TX_BITS = 4'd8;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
        logic       ovf;
    } t_pair;

    // One count step of a low/high pair in modes 0..2; split mode holds.
    function automatic t_pair count_pair(logic [1:0] mode, logic [7:0] lo, logic [7:0] hi);
        t_pair      r;
        logic [5:0] v5;
        logic [8:0] v8;
        logic [8:0] h8;
        r.lo  = lo;
        r.hi  = hi;
        r.ovf = 1'b0;
        h8    = {1'b0, hi} + 9'd1;
        unique case (mode)
            MODE_13BIT: begin
                v5   = {1'b0, lo[4:0]} + 6'd1;
                r.lo = {lo[7:5], v5[4:0]};
                if (v5[5]) begin
                    r.hi  = h8[7:0];
                    r.ovf = h8[8];
                end
            end
            MODE_16BIT: begin
                v8   = {1'b0, lo} + 9'd1;
                r.lo = v8[7:0];
                if (v8[8]) begin
                    r.hi  = h8[7:0];
                    r.ovf = h8[8];
                end
            end
            MODE_RELOAD: begin
                v8 = {1'b0, lo} + 9'd1;
                if (v8[8]) begin
                    r.lo  = hi;
                    r.ovf = 1'b1;
                end else begin
                    r.lo = v8[7:0];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

endpackage

/* sv/timer_pair_with_serial_shift.sv */
// Top level: two 8051-style timers and a serial transmit shifter.
// Depends on tpss_pkg for codes and the counter step function.
//
// Result: the output register loads an item's result at the edge that accepts it.
// Throughput: 1 item per cycle; the state update and the result register load
//   in the same edge, so only a stalled, full output register holds the input.
// Reset: synchronous, active low; timers, TCON, shifter and flags clear,
//   the pin level goes high, r_bit_count returns to 8, the output goes empty.
module timer_pair_with_serial_shift (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_in_op,
    input  logic [2:0] i_in_reg_sel,
    input  logic [7:0] i_in_write_data,
    // result output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_read_data,
    output logic       o_out_txd_level,
    output logic       o_out_overflow0,
    output logic       o_out_overflow1,
    output logic       o_out_tx_done,
    output logic       o_out_serial_irq,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import tpss_pkg::*;

    // configuration registers
    logic [7:0] r_timer_mode;
    logic       r_shift_mode;
    logic       r_irq_enable;
    logic [3:0] r_bit_count;

    // block state
    logic [7:0] r_tl0, r_th0, r_tl1, r_th1;
    logic [7:0] r_tcon;
    logic [7:0] r_sbuf;
    logic [3:0] r_bits_left;
    logic       r_pin;
    logic       r_tx_flag;
    logic       r_irq;

    logic [7:0] n_tl0, n_th0, n_tl1, n_th1;
    logic [7:0] n_tcon;
    logic [7:0] n_sbuf;
    logic [3:0] n_bits_left;
    logic       n_pin;
    logic       n_tx_flag;
    logic       n_irq;
    logic [7:0] n_read_data;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_read_data;
    logic       r_out_txd, r_out_ovf0, r_out_ovf1, r_out_tx_done, r_out_irq;

    logic       in_accept;
    logic [3:0] nib0, nib1;
    logic [1:0] mode0, mode1;
    logic       split, run0, run1;
    t_pair      pair0, pair1;
    logic [3:0] bits_dec;
    t_op        op;

    // Input waits only while a result sits in the output register and is stalled.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign nib0  = r_timer_mode[3:0];
    assign nib1  = r_timer_mode[7:4];
    assign mode0 = nib0[1:0];
    assign mode1 = nib1[1:0];
    assign split = (mode0 == MODE_SPLIT);
    // counter-select and gate both clear, run bit set
    assign run0  = (nib0[3:2] == 2'b00) & r_tcon[TCON_TR0];
    assign run1  = (nib1[3:2] == 2'b00) & r_tcon[TCON_TR1];
    assign pair0 = count_pair(mode0, r_tl0, r_th0);
    assign pair1 = count_pair(mode1, r_tl1, r_th1);
    assign bits_dec = r_bits_left - 4'd1;
    assign op    = t_op'(i_in_op);

    always_comb begin
        n_tl0       = r_tl0;
        n_th0       = r_th0;
        n_tl1       = r_tl1;
        n_th1       = r_th1;
        n_tcon      = r_tcon;
        n_sbuf      = r_sbuf;
        n_bits_left = r_bits_left;
        n_pin       = r_pin;
        n_tx_flag   = r_tx_flag;
        n_irq       = r_irq;
        n_read_data = 8'd0;

        unique case (op)
            OP_TICK: begin
                if (split) begin
                    // TL0 under timer 0 control, TH0 borrows timer 1 control
                    if (run0) begin
                        if (r_tl0 == 8'hff) n_tcon[TCON_TF0] = 1'b1;
                        n_tl0 = r_tl0 + 8'd1;
                    end
                    if (run1) begin
                        if (r_th0 == 8'hff) n_tcon[TCON_TF1] = 1'b1;
                        n_th0 = r_th0 + 8'd1;
                    end
                end else if (run0) begin
                    n_tl0 = pair0.lo;
                    n_th0 = pair0.hi;
                    if (pair0.ovf) n_tcon[TCON_TF0] = 1'b1;
                end

                if (run1) begin
                    n_tl1 = pair1.lo;
                    n_th1 = pair1.hi;
                    if (pair1.ovf && !split) n_tcon[TCON_TF1] = 1'b1;
                    // a set TF1 shifts out the next transmit bit, MSB first, and is consumed
                    if (n_tcon[TCON_TF1] && r_shift_mode) begin
                        if (r_bits_left != 4'd0) begin
                            n_bits_left = bits_dec;
                            n_pin       = r_sbuf[bits_dec[2:0]];
                            if (bits_dec == 4'd0) begin
                                n_tx_flag = 1'b1;
                                if (r_irq_enable) n_irq = 1'b1;
                            end
                        end
                        n_tcon[TCON_TF1] = 1'b0;
                    end
                end
            end
            OP_WRITE: begin
                unique case (i_in_reg_sel)
                    SEL_TL0:  n_tl0  = i_in_write_data;
                    SEL_TH0:  n_th0  = i_in_write_data;
                    SEL_TL1:  n_tl1  = i_in_write_data;
                    SEL_TH1:  n_th1  = i_in_write_data;
                    SEL_TCON: n_tcon = i_in_write_data;
                    SEL_SBUF: begin
                        // restarts any shift in progress
                        n_sbuf      = i_in_write_data;
                        n_bits_left = (r_bit_count > MAX_TX_BITS) ? MAX_TX_BITS : r_bit_count;
                    end
                    SEL_STATUS: begin
                        n_tx_flag = i_in_write_data[1];
                        n_irq     = i_in_write_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            OP_READ: begin
                unique case (i_in_reg_sel)
                    SEL_TL0:    n_read_data = r_tl0;
                    SEL_TH0:    n_read_data = r_th0;
                    SEL_TL1:    n_read_data = r_tl1;
                    SEL_TH1:    n_read_data = r_th1;
                    SEL_TCON:   n_read_data = r_tcon;
                    SEL_SBUF:   n_read_data = r_sbuf;
                    SEL_STATUS: n_read_data = {6'd0, r_tx_flag, r_irq};
                    default:    n_read_data = 8'd0;
                endcase
            end
            default: begin
                // unused op code: no change
            end
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_mode <= 8'd0;
            r_shift_mode <= 1'b0;
            r_irq_enable <= 1'b0;
            r_bit_count  <= MAX_TX_BITS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TIMER_MODE: r_timer_mode <= i_cfg_data;
                CFG_SHIFT_MODE: r_shift_mode <= i_cfg_data[0];
                CFG_IRQ_ENABLE: r_irq_enable <= i_cfg_data[0];
                CFG_BIT_COUNT:  r_bit_count  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl0       <= 8'd0;
            r_th0       <= 8'd0;
            r_tl1       <= 8'd0;
            r_th1       <= 8'd0;
            r_tcon      <= 8'd0;
            r_sbuf      <= 8'd0;
            r_bits_left <= 4'd0;
            r_pin       <= 1'b1;
            r_tx_flag   <= 1'b0;
            r_irq       <= 1'b0;
        end else if (in_accept) begin
            r_tl0       <= n_tl0;
            r_th0       <= n_th0;
            r_tl1       <= n_tl1;
            r_th1       <= n_th1;
            r_tcon      <= n_tcon;
            r_sbuf      <= n_sbuf;
            r_bits_left <= n_bits_left;
            r_pin       <= n_pin;
            r_tx_flag   <= n_tx_flag;
            r_irq       <= n_irq;
        end
    end

    // output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register: payload, flags taken after the item's update
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_read_data <= n_read_data;
            r_out_txd       <= n_pin;
            r_out_ovf0      <= n_tcon[TCON_TF0];
            r_out_ovf1      <= n_tcon[TCON_TF1];
            r_out_tx_done   <= n_tx_flag;
            r_out_irq       <= n_irq;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_read_data  = r_out_read_data;
    assign o_out_txd_level  = r_out_txd;
    assign o_out_overflow0  = r_out_ovf0;
    assign o_out_overflow1  = r_out_ovf1;
    assign o_out_tx_done    = r_out_tx_done;
    assign o_out_serial_irq = r_out_irq;

endmodule

/* sim/tb_timer_pair_with_serial_shift.sv */
// Self-checking testbench for timer_pair_with_serial_shift: timer, TCON and serial shift items.
// Predicts every result in a cycle-free timer model and checks it field by field.
// Depends on tpss_pkg and the timer_pair_with_serial_shift RTL.
module tb_timer_pair_with_serial_shift;
    timeunit 1ns;
    timeprecision 1ps;

    import tpss_pkg::*;

    // Codes that the package leaves unnamed: the spare op and the spare select.
    localparam logic [1:0] OP_NONE  = 2'd3;
    localparam logic [2:0] SEL_NONE = 3'd7;

    localparam logic [7:0] TR0_MASK = 8'(1 << TCON_TR0);
    localparam logic [7:0] TR1_MASK = 8'(1 << TCON_TR1);

    // Cycles with no handshake at all before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] sel;
        logic [7:0] data;
    } t_timer_op;

    typedef struct packed {
        logic [7:0] read_data;
        logic       txd;
        logic       tf0;
        logic       tf1;
        logic       ti;
        logic       irq;
    } t_status;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
        logic       wrap;
    } t_count;

    // DUT connections; every input starts at a known value.
    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic [1:0] i_in_op         = '0;
    logic [2:0] i_in_reg_sel    = '0;
    logic [7:0] i_in_write_data = '0;
    logic       i_out_stall     = 1'b0;
    logic       i_cfg_valid     = 1'b0;
    logic [1:0] i_cfg_index     = '0;
    logic [7:0] i_cfg_data      = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_read_data;
    logic       o_out_txd_level;
    logic       o_out_overflow0;
    logic       o_out_overflow1;
    logic       o_out_tx_done;
    logic       o_out_serial_irq;
    logic       o_cfg_ready;

    timer_pair_with_serial_shift uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_op          (i_in_op),
        .i_in_reg_sel     (i_in_reg_sel),
        .i_in_write_data  (i_in_write_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_read_data  (o_out_read_data),
        .o_out_txd_level  (o_out_txd_level),
        .o_out_overflow0  (o_out_overflow0),
        .o_out_overflow1  (o_out_overflow1),
        .o_out_tx_done    (o_out_tx_done),
        .o_out_serial_irq (o_out_serial_irq),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Items waiting for the driver, and status words waiting for the DUT.
    t_timer_op   op_queue[$];
    t_status     status_queue[$];

    int unsigned n_queued     = 0;  // items handed to the driver
    int unsigned n_effective  = 0;  // same, minus items the block ignores
    int unsigned n_checked    = 0;  // results compared
    int unsigned n_errors     = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    // Predicted settings and state of the block.
    logic [7:0] tmod;
    logic       shift_en;
    logic       irq_en;
    logic [3:0] load_bits;
    logic [7:0] tl0, th0, tl1, th1;
    logic [7:0] tcon;
    logic [7:0] sbuf;
    logic [3:0] bits_pending;
    logic       txd;
    logic       ti_flag;
    logic       irq_flag;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Timer / shifter prediction
    // ------------------------------------------------------------------
    function automatic void clear_timers();
        tmod         = '0;
        shift_en     = 1'b0;
        irq_en       = 1'b0;
        load_bits    = MAX_TX_BITS;
        tl0          = '0;
        th0          = '0;
        tl1          = '0;
        th1          = '0;
        tcon         = '0;
        sbuf         = '0;
        bits_pending = '0;
        txd          = 1'b1;   // idle line is high
        ti_flag      = 1'b0;
        irq_flag     = 1'b0;
    endfunction

    function automatic void write_setting(logic [1:0] idx, logic [7:0] data);
        case (idx)
            CFG_TIMER_MODE: tmod      = data;
            CFG_SHIFT_MODE: shift_en  = data[0];
            CFG_IRQ_ENABLE: irq_en    = data[0];
            CFG_BIT_COUNT:  load_bits = data[3:0];
            default: ;
        endcase
    endfunction

    // One count of a low/high pair; split mode leaves it alone.
    function automatic t_count bump_pair(logic [1:0] mode, logic [7:0] lo, logic [7:0] hi);
        t_count     r;
        logic [5:0] s5;
        logic [8:0] s9;
        logic [8:0] h9;
        r.lo   = lo;
        r.hi   = hi;
        r.wrap = 1'b0;
        h9     = {1'b0, hi} + 9'd1;
        case (mode)
            MODE_13BIT: begin
                s5       = {1'b0, lo[4:0]} + 6'd1;
                r.lo[4:0] = s5[4:0];
                if (s5[5])
                    {r.wrap, r.hi} = h9;
            end
            MODE_16BIT: begin
                s9   = {1'b0, lo} + 9'd1;
                r.lo = s9[7:0];
                if (s9[8])
                    {r.wrap, r.hi} = h9;
            end
            MODE_RELOAD: begin
                if (lo == 8'hff) begin
                    r.lo   = hi;
                    r.wrap = 1'b1;
                end else begin
                    r.lo = lo + 8'd1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Shift one transmit bit, MSB first; the last one raises TI.
    function automatic void shift_bit();
        if (bits_pending != 0) begin
            bits_pending = bits_pending - 4'd1;
            txd          = sbuf[bits_pending[2:0]];
            if (bits_pending == 0) begin
                ti_flag = 1'b1;
                if (irq_en)
                    irq_flag = 1'b1;
            end
        end
    endfunction

    function automatic void tick_timers();
        logic [3:0] n0;
        logic [3:0] n1;
        logic       split;
        logic       run0;
        logic       run1;
        t_count     c;
        n0    = tmod[3:0];
        n1    = tmod[7:4];
        split = (n0[1:0] == MODE_SPLIT);
        // gate or counter select set: no external source, so no counting
        run0  = (n0[3:2] == 2'b00) && tcon[TCON_TR0];
        run1  = (n1[3:2] == 2'b00) && tcon[TCON_TR1];
        if (split) begin
            // TL0 under timer 0 control, TH0 borrowed by timer 1
            if (run0) begin
                if (tl0 == 8'hff)
                    tcon[TCON_TF0] = 1'b1;
                tl0 = tl0 + 8'd1;
            end
            if (run1) begin
                if (th0 == 8'hff)
                    tcon[TCON_TF1] = 1'b1;
                th0 = th0 + 8'd1;
            end
        end else if (run0) begin
            c   = bump_pair(n0[1:0], tl0, th0);
            tl0 = c.lo;
            th0 = c.hi;
            if (c.wrap)
                tcon[TCON_TF0] = 1'b1;
        end
        if (run1) begin
            c   = bump_pair(n1[1:0], tl1, th1);
            tl1 = c.lo;
            th1 = c.hi;
            if (c.wrap && !split)
                tcon[TCON_TF1] = 1'b1;
            // TF1 shifts out the next bit and is consumed, even with nothing to send
            if (tcon[TCON_TF1] && shift_en) begin
                shift_bit();
                tcon[TCON_TF1] = 1'b0;
            end
        end
    endfunction

    // Apply one item to the predicted state and return the status it yields.
    function automatic t_status step_timers(logic [1:0] op, logic [2:0] sel, logic [7:0] data);
        t_status s;
        s.read_data = '0;
        case (op)
            OP_TICK: tick_timers();
            OP_WRITE: begin
                case (sel)
                    SEL_TL0:  tl0  = data;
                    SEL_TH0:  th0  = data;
                    SEL_TL1:  tl1  = data;
                    SEL_TH1:  th1  = data;
                    SEL_TCON: tcon = data;
                    SEL_SBUF: begin
                        sbuf         = data;
                        bits_pending = (load_bits > MAX_TX_BITS) ? MAX_TX_BITS : load_bits;
                    end
                    SEL_STATUS: begin
                        ti_flag  = data[1];
                        irq_flag = data[0];
                    end
                    default: ;
                endcase
            end
            OP_READ: begin
                case (sel)
                    SEL_TL0:    s.read_data = tl0;
                    SEL_TH0:    s.read_data = th0;
                    SEL_TL1:    s.read_data = tl1;
                    SEL_TH1:    s.read_data = th1;
                    SEL_TCON:   s.read_data = tcon;
                    SEL_SBUF:   s.read_data = sbuf;
                    SEL_STATUS: s.read_data = {6'd0, ti_flag, irq_flag};
                    default:    s.read_data = '0;
                endcase
            end
            default: ;
        endcase
        s.txd = txd;
        s.tf0 = tcon[TCON_TF0];
        s.tf1 = tcon[TCON_TF1];
        s.ti  = ti_flag;
        s.irq = irq_flag;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic compare_status(t_status want);
        if (o_out_read_data !== want.read_data)
            note_mismatch("read_data", want.read_data, o_out_read_data);
        if (o_out_txd_level !== want.txd)
            note_mismatch("txd_level", want.txd, o_out_txd_level);
        if (o_out_overflow0 !== want.tf0)
            note_mismatch("overflow0", want.tf0, o_out_overflow0);
        if (o_out_overflow1 !== want.tf1)
            note_mismatch("overflow1", want.tf1, o_out_overflow1);
        if (o_out_tx_done !== want.ti)
            note_mismatch("tx_done", want.ti, o_out_tx_done);
        if (o_out_serial_irq !== want.irq)
            note_mismatch("serial_irq", want.irq, o_out_serial_irq);
    endtask

    // Monitor: checks results first, then predicts the item accepted at the same
    // edge, so a result can never be matched against its own item.
    always @(posedge i_clk) begin : monitor
        logic progress;
        progress = 1'b0;
        if (!i_rst_n) begin
            clear_timers();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                progress = 1'b1;
                if (status_queue.size() == 0) begin
                    note_mismatch("result with no item outstanding", 0, o_out_read_data);
                end else begin
                    compare_status(status_queue.pop_front());
                    n_checked <= n_checked + 1;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                progress = 1'b1;
                status_queue.push_back(step_timers(i_in_op, i_in_reg_sel, i_in_write_data));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                progress = 1'b1;
                write_setting(i_cfg_index, i_cfg_data);
            end
        end
        quiet_cycles <= progress ? 0 : quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Driver and receiver
    // ------------------------------------------------------------------
    // A new item is taken only once the current one is gone; an idle gap is
    // decided only while no item is held, so valid never drops under stall.
    always @(posedge i_clk) begin : driver
        t_timer_op t;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t = op_queue.pop_front();
                i_in_valid      <= 1'b1;
                i_in_op         <= t.op;
                i_in_reg_sel    <= t.sel;
                i_in_write_data <= t.data;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: a run with no handshake for too long is hung.
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("tb_timer_pair_with_serial_shift: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_op(logic [1:0] op, logic [2:0] sel, logic [7:0] data);
        t_timer_op t;
        t.op   = op;
        t.sel  = sel;
        t.data = data;
        op_queue.push_back(t);
        n_queued++;
        // spare op codes and writes to the spare select do nothing
        if (op != OP_NONE && !(op == OP_WRITE && sel == SEL_NONE))
            n_effective++;
    endtask

    // Ticks carry random junk in the fields they do not use.
    task automatic add_ticks(int n);
        repeat (n) add_op(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom));
    endtask

    // Counter preload biased toward the wrap point of each mode.
    function automatic logic [7:0] preload();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom);
            1:       return {3'($urandom), 5'($urandom_range(28, 31))};
            default: return 8'($urandom_range(224, 255));
        endcase
    endfunction

    // TCON byte with the run bits mostly set, the rest random.
    function automatic logic [7:0] tcon_byte();
        logic [7:0] d;
        d = 8'($urandom);
        d[TCON_TR0] = ($urandom_range(0, 3) != 0);
        d[TCON_TR1] = ($urandom_range(0, 3) != 0);
        return d;
    endfunction

    task automatic wait_drained();
        while (n_checked != n_queued)
            @(posedge i_clk);
    endtask

    // Valid stays high across back-to-back writes; the caller lowers it.
    task automatic cfg_write(logic [1:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Settings change only with the block drained.
    task automatic configure(logic [7:0] mode, logic sm1, logic es, logic [3:0] nbits,
                             int unsigned idle, int unsigned stall);
        wait_drained();
        @(posedge i_clk);
        cfg_write(CFG_TIMER_MODE, mode);
        cfg_write(CFG_SHIFT_MODE, {7'd0, sm1});
        cfg_write(CFG_IRQ_ENABLE, {7'd0, es});
        cfg_write(CFG_BIT_COUNT, {4'd0, nbits});
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        send_idle_pct = idle;
        stall_pct     = stall;
    endtask

    // Random part: mostly well-formed count and transmit sequences, some noise.
    task automatic add_random(int unsigned count);
        int unsigned goal;
        int unsigned kind;
        logic        tmr;
        goal = n_effective + count;
        while (n_effective < goal) begin
            kind = $urandom_range(0, 99);
            tmr  = 1'($urandom);
            if (kind < 35) begin
                // preload a timer, start it, let it run, look at it
                if ($urandom_range(0, 1))
                    add_op(OP_WRITE, tmr ? SEL_TL1 : SEL_TL0, preload());
                if ($urandom_range(0, 1))
                    add_op(OP_WRITE, tmr ? SEL_TH1 : SEL_TH0, preload());
                add_op(OP_WRITE, SEL_TCON, tcon_byte());
                add_ticks($urandom_range(2, 30));
                add_op(OP_READ, 3'($urandom_range(0, 4)), 8'($urandom));
            end else if (kind < 70) begin
                // transmit: fast timer 1 overflow, load SBUF, clock it out
                if ($urandom_range(0, 1)) begin
                    add_op(OP_WRITE, SEL_TH1, preload());
                    add_op(OP_WRITE, SEL_TL1, preload());
                end
                if ($urandom_range(0, 3) == 0)
                    add_op(OP_WRITE, SEL_TH0, preload());
                add_op(OP_WRITE, SEL_SBUF, 8'($urandom));
                if ($urandom_range(0, 2) != 0)
                    add_op(OP_WRITE, SEL_TCON, tcon_byte() | TR1_MASK);
                add_ticks($urandom_range(1, 12));
                if ($urandom_range(0, 3) == 0) begin
                    // reload while still shifting
                    add_op(OP_WRITE, SEL_SBUF, 8'($urandom));
                    add_ticks($urandom_range(1, 10));
                end
                add_op(OP_READ, SEL_STATUS, 8'($urandom));
                if ($urandom_range(0, 1))
                    add_op(OP_WRITE, SEL_STATUS, 8'($urandom));
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 6)) begin
                    add_op(OP_READ, 3'($urandom_range(0, 7)), 8'($urandom));
                    add_ticks($urandom_range(0, 2));
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    add_op(2'($urandom), 3'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset settings (both timers 13-bit, no serial shifting):
        // wrap both timers on one tick, walk the register map and its edges.
        add_op(OP_READ,  SEL_STATUS, 8'h00);
        add_op(OP_WRITE, SEL_TL0,    8'h1f);
        add_op(OP_WRITE, SEL_TH0,    8'hff);
        add_op(OP_WRITE, SEL_TL1,    8'hff);
        add_op(OP_WRITE, SEL_TH1,    8'hff);
        add_op(OP_WRITE, SEL_TCON,   TR0_MASK | TR1_MASK);
        add_op(OP_TICK,  SEL_TL0,    8'h00);
        add_op(OP_READ,  SEL_TH0,    8'h00);
        add_op(OP_WRITE, SEL_SBUF,   8'ha5);
        add_op(OP_READ,  SEL_SBUF,   8'hff);
        add_op(OP_WRITE, SEL_STATUS, 8'hff);       // sets TI and the interrupt flag
        add_op(OP_WRITE, SEL_STATUS, 8'hfc);       // only bits 1..0 matter
        add_op(OP_NONE,  SEL_NONE,   8'hff);       // spare op: no effect
        add_op(OP_WRITE, SEL_NONE,   8'hff);       // spare select: ignored
        add_op(OP_READ,  SEL_NONE,   8'h00);       // spare select reads zero
        add_op(OP_WRITE, SEL_TCON,   8'hff);
        add_op(OP_TICK,  SEL_NONE,   8'hff);
        add_op(OP_READ,  SEL_TCON,   8'h00);

        // Timer 1 auto-reload at the top: TF1 every tick, bit count above eight.
        configure(8'h21, 1'b1, 1'b1, 4'd15, 0, 0);
        add_op(OP_WRITE, SEL_TH1,  8'hff);
        add_op(OP_WRITE, SEL_TL1,  8'hff);
        add_op(OP_WRITE, SEL_SBUF, 8'h81);
        add_op(OP_WRITE, SEL_TCON, TR1_MASK);
        add_ticks(10);                              // last two shift nothing
        add_op(OP_READ,  SEL_STATUS, 8'h00);
        add_random(130);

        configure(8'h20, 1'b1, 1'b0, 4'd8, 45, 0);
        add_random(140);
        // timer 0 split, TH0 drives TF1
        configure(8'h23, 1'b1, 1'b1, 4'd1, 0, 45);
        add_random(140);
        // timer 1 in mode 3 holds, TF1 from TCON writes still shifts
        configure(8'h32, 1'b1, 1'b1, 4'd8, 21, 21);
        add_random(140);
        // zero bit count: SBUF writes send nothing
        configure(8'h00, 1'b1, 1'b0, 4'd0, 0, 0);
        add_random(140);
        // every gate and counter select set: nothing counts
        configure(8'hff, 1'b1, 1'b1, 4'd8, 45, 0);
        add_random(140);
        configure(8'($urandom), 1'($urandom), 1'($urandom), 4'($urandom), 0, 45);
        add_random(140);
        configure(8'h22, 1'b1, 1'b1, 4'd3, 21, 21);
        add_random(140);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (n_errors == 0 && status_queue.size() == 0) begin
            $display("tb_timer_pair_with_serial_shift: clean");
        end else begin
            $display("tb_timer_pair_with_serial_shift: errors");
        end
        $finish;
    end

endmodule
